// ===== hw/rtl/mvq_pkg.sv =====
// Shared constants for the minimum-weight vertex queue.
// Field widths, operation and status codes, default sizes.
// No dependencies.
package mvq_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int WEIGHT_BITS_DEF  = 32;

	localparam int KIND_W   = 3;
	localparam int VID_W    = 6;
	localparam int NEWW_W   = 32;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EXISTS = 3'd3;
	localparam logic [KIND_W-1:0] KIND_POP    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ===== hw/rtl/mvq_if.sv =====
// Request and response channel interfaces of the vertex queue.
// Depends on mvq_pkg for field widths.
interface mvq_req_if import mvq_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [VID_W-1:0]  vertex_id;
	logic [NEWW_W-1:0] new_weight;

	modport source(output valid, kind, vertex_id, new_weight, input ready);
	modport sink(input valid, kind, vertex_id, new_weight, output ready);
endinterface

interface mvq_rsp_if import mvq_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [VID_W-1:0]    popped_vertex;
	logic                is_present;
	logic [STATUS_W-1:0] status;

	modport source(output valid, popped_vertex, is_present, status, input ready);
	modport sink(input valid, popped_vertex, is_present, status, output ready);
endinterface

// ===== hw/rtl/mvq_cell.sv =====
// One slot cell of the rotating slot ring.
// Holds one vertex index and takes its neighbor's value on shift.
module mvq_cell #(
	parameter int IW = 6
) (
	input  logic          clk,
	input  logic          shift,
	input  logic [IW-1:0] din,
	output logic [IW-1:0] dout
);

	logic [IW-1:0] vert_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			vert_q <= din;
		end
	end

	assign dout = vert_q;

endmodule

// ===== hw/rtl/min_weight_vertex_queue.sv =====
// Minimum-weight vertex queue: weight memory plus a ring of slot cells.
// Steps: update writes the weight memory directly, exists reads it back, insert
// rotates the ring over all slots, remove and pop scan every slot and then rotate
// the ring again; the result is then loaded into the output register. One
// transaction is worked at a time. Reset: asynchronous; a clearing pass then
// fills the weight memory with all ones, during which no request is taken.
module min_weight_vertex_queue import mvq_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	mvq_req_if.sink   req,
	mvq_rsp_if.source rsp
);

	localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic [CW-1:0] MAXC  = CW'(MAX_VERTICES);
	localparam logic [CW-1:0] LASTC = CW'(MAX_VERTICES - 1);
	localparam logic [WEIGHT_BITS-1:0] ABSENT = '1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_DRN  = 3'd3;
	localparam logic [2:0] S_DEC  = 3'd4;
	localparam logic [2:0] S_FIX  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]             state_q;
	logic [CW-1:0]          clr_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          j_q;
	logic [KIND_W-1:0]      op_q;
	logic [IW-1:0]          vid_q;
	logic                   found_q;
	logic [WEIGHT_BITS-1:0] best_w_q;
	logic [IW-1:0]          best_i_q;
	logic [IW-1:0]          best_v_q;
	logic [IW-1:0]          last_q;
	logic [VID_W-1:0]       res_pop_q;
	logic                   res_pres_q;
	logic [STATUS_W-1:0]    res_stat_q;
	logic                   rsp_valid_q;
	logic [VID_W-1:0]       rsp_pop_q;
	logic                   rsp_pres_q;
	logic [STATUS_W-1:0]    rsp_stat_q;

	logic                   act_s1;
	logic                   ok_s1;
	logic [IW-1:0]          i_s1;
	logic [IW-1:0]          v_s1;

	logic [WEIGHT_BITS-1:0] wmem [MAX_VERTICES];
	logic [WEIGHT_BITS-1:0] rdata_q;
	logic                   we;
	logic [IW-1:0]          wa;
	logic [WEIGHT_BITS-1:0] wd;
	logic [IW-1:0]          ra;

	logic                   clearing;
	logic                   accept;
	logic                   in_range;
	logic [IW-1:0]          vid_idx;
	logic [63:0]            neww_wide;
	logic [WEIGHT_BITS-1:0] w_in;
	logic                   shift;
	logic [IW-1:0]          head;
	logic [IW-1:0]          tail_in;
	logic [IW-1:0]          ring [MAX_VERTICES];
	logic                   rsp_free;

	assign clearing  = (clr_q != MAXC);
	assign req.ready = (state_q == S_IDLE) && !clearing;
	assign accept    = req.valid && req.ready;
	assign in_range  = 32'(req.vertex_id) < MAX_VERTICES;
	assign vid_idx   = IW'(32'(req.vertex_id));
	assign neww_wide = 64'(req.new_weight);
	assign w_in      = neww_wide[WEIGHT_BITS-1:0];
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	// slot ring: cell 0 is the head, values move toward it
	assign head  = ring[0];
	assign shift = (state_q == S_SCAN) || (state_q == S_FIX);
	assign tail_in = ((state_q == S_FIX) && (j_q[IW-1:0] == best_i_q)) ? last_q : head;

	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
		mvq_cell #(.IW(IW)) u_cell (
			.clk  (clk),
			.shift(shift),
			.din  ((k == MAX_VERTICES - 1) ? tail_in : ring[(k + 1) % MAX_VERTICES]),
			.dout (ring[k])
		);
	end

	// weight memory port control
	always_comb begin
		we = 1'b0;
		wa = vid_idx;
		wd = w_in;
		if (clearing) begin
			we = 1'b1;
			wa = clr_q[IW-1:0];
			wd = ABSENT;
		end else if (accept && in_range &&
				(req.kind == KIND_UPDATE ||
				(req.kind == KIND_INSERT && count_q != MAXC))) begin
			we = 1'b1;
		end else if (state_q == S_DEC && found_q) begin
			we = 1'b1;
			wa = best_v_q;
			wd = ABSENT;
		end
		ra = (state_q == S_IDLE) ? vid_idx : head;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			wmem[wa] <= wd;
		end
		rdata_q <= wmem[ra];
	end

	always_ff @(posedge clk) begin
		v_s1  <= head;
		i_s1  <= j_q[IW-1:0];
		ok_s1 <= (j_q < count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clr_q       <= '0;
			count_q     <= '0;
			j_q         <= '0;
			op_q        <= KIND_INSERT;
			found_q     <= 1'b0;
			act_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
			act_s1 <= (state_q == S_SCAN);
			// S_DONE reloads the output register itself
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end

			// scan compare, one slot per cycle behind the memory read
			if (act_s1 && ok_s1) begin
				if (i_s1 == IW'(count_q - 1'b1)) begin
					last_q <= v_s1;
				end
				if (op_q == KIND_POP) begin
					if (!found_q || rdata_q < best_w_q) begin
						found_q  <= 1'b1;
						best_w_q <= rdata_q;
						best_i_q <= i_s1;
						best_v_q <= v_s1;
					end
				end else if (!found_q && v_s1 == vid_q) begin
					found_q  <= 1'b1;
					best_i_q <= i_s1;
					best_v_q <= v_s1;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q       <= req.kind;
						vid_q      <= vid_idx;
						found_q    <= 1'b0;
						j_q        <= '0;
						res_pop_q  <= '0;
						res_pres_q <= 1'b0;
						res_stat_q <= ST_OK;
						state_q    <= S_DONE;
						case (req.kind)
							KIND_INSERT: begin
								if (in_range) begin
									if (count_q == MAXC) begin
										res_stat_q <= ST_FULL;
									end else begin
										best_i_q <= count_q[IW-1:0];
										last_q   <= vid_idx;
										count_q  <= count_q + 1'b1;
										state_q  <= S_FIX;
									end
								end
							end
							KIND_REMOVE: begin
								if (in_range) begin
									state_q <= S_SCAN;
								end else begin
									res_stat_q <= ST_NOT_FOUND;
								end
							end
							KIND_EXISTS: begin
								if (in_range) begin
									state_q <= S_READ;
								end
							end
							KIND_POP: begin
								if (count_q == '0) begin
									res_stat_q <= ST_EMPTY;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					res_pres_q <= (rdata_q != ABSENT);
					state_q    <= S_DONE;
				end
				S_SCAN: begin
					j_q <= j_q + 1'b1;
					if (j_q == LASTC) begin
						state_q <= S_DRN;
					end
				end
				S_DRN: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					j_q <= '0;
					if (found_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_FIX;
						if (op_q == KIND_POP) begin
							res_pop_q <= VID_W'(32'(best_v_q));
						end
					end else begin
						res_stat_q <= ST_NOT_FOUND;
						state_q    <= S_DONE;
					end
				end
				S_FIX: begin
					j_q <= j_q + 1'b1;
					if (j_q == LASTC) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						rsp_pop_q   <= res_pop_q;
						rsp_pres_q  <= res_pres_q;
						rsp_stat_q  <= res_stat_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.popped_vertex = rsp_pop_q;
	assign rsp.is_present    = rsp_pres_q;
	assign rsp.status        = rsp_stat_q;

endmodule

// ===== sim/tb_min_weight_vertex_queue.sv =====
// Testbench for min_weight_vertex_queue: directed table, then random traffic,
// checked against an in-bench model of the weight table and slot list.
// Depends on mvq_pkg, mvq_if.sv and the block's RTL.
`timescale 1ns / 1ps

module tb_min_weight_vertex_queue;
	import mvq_pkg::*;

	localparam int NV = MAX_VERTICES_DEF;
	localparam logic [NEWW_W-1:0] W_ABSENT = '1;
	localparam logic [KIND_W-1:0] KIND_RSVD5 = 3'd5;
	localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;
	localparam int IDLE_LIMIT = 3000;
	localparam int RAND_ITEMS = 1000;

	typedef struct packed {
		logic [VID_W-1:0]    popped;
		logic                present;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [VID_W-1:0]  vid;
		logic [NEWW_W-1:0] w;
		logic              has_exp;
		rsp_t              exp;
	} op_t;

	logic clk;
	logic arst_n;

	mvq_req_if req_if();
	mvq_rsp_if rsp_if();

	min_weight_vertex_queue u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// model state
	logic [VID_W-1:0]  q_slot [NV];
	int                q_count;
	logic [NEWW_W-1:0] q_weight [NV];

	rsp_t pending_rsp[$];
	op_t  directed_ops[$];
	op_t  cur_op;
	int   mismatches;
	int   idle_cycles;
	bit   hold_req;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic rsp_t row_exp(int p, int pr, logic [STATUS_W-1:0] st);
		rsp_t r;
		r.popped = VID_W'(p);
		r.present = (pr != 0);
		r.status = st;
		return r;
	endfunction

	function automatic void add_row(logic [KIND_W-1:0] k, int v,
			logic [NEWW_W-1:0] w, int he, rsp_t e);
		op_t o;
		o.kind = k;
		o.vid = VID_W'(v);
		o.w = w;
		o.has_exp = (he != 0);
		o.exp = e;
		directed_ops.push_back(o);
	endfunction

	function automatic void drop_slot_at(int idx);
		logic [VID_W-1:0] v;
		v = q_slot[idx];
		q_weight[v] = W_ABSENT;
		q_slot[idx] = q_slot[q_count-1];
		q_slot[q_count-1] = v;
		q_count--;
	endfunction

	function automatic rsp_t queue_outcome(logic [KIND_W-1:0] k, logic [VID_W-1:0] v,
			logic [NEWW_W-1:0] w);
		rsp_t r;
		int best;
		logic [NEWW_W-1:0] best_w;
		r = '0;
		case (k)
			KIND_INSERT: begin
				if (q_count >= NV) begin
					r.status = ST_FULL;
				end else begin
					q_slot[q_count] = v;
					q_count++;
					q_weight[v] = w;
				end
			end
			KIND_UPDATE: q_weight[v] = w;
			KIND_REMOVE: begin
				r.status = ST_NOT_FOUND;
				for (int i = 0; i < q_count; i++) begin
					if (q_slot[i] == v) begin
						drop_slot_at(i);
						r.status = ST_OK;
						break;
					end
				end
			end
			KIND_EXISTS: r.present = (q_weight[v] != W_ABSENT);
			KIND_POP: begin
				if (q_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					best = 0;
					best_w = q_weight[q_slot[0]];
					for (int i = 1; i < q_count; i++) begin
						if (q_weight[q_slot[i]] < best_w) begin
							best_w = q_weight[q_slot[i]];
							best = i;
						end
					end
					r.popped = q_slot[best];
					drop_slot_at(best);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// checker and predictor, both at the rising edge
	always @(posedge clk) begin
		rsp_t got, want, pred;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				got.popped = rsp_if.popped_vertex;
				got.present = rsp_if.is_present;
				got.status = rsp_if.status;
				if (pending_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response %h", got);
				end else begin
					want = pending_rsp.pop_front();
					if (got.popped !== want.popped || got.present !== want.present ||
							got.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: popped %0d/%0d present %0d/%0d status %0d/%0d",
								want.popped, got.popped, want.present, got.present,
								want.status, got.status);
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				pred = queue_outcome(req_if.kind, req_if.vertex_id, req_if.new_weight);
				pending_rsp.push_back(cur_op.has_exp ? cur_op.exp : pred);
			end
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_op(op_t o);
		int gap;
		gap = $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
		end
		@(negedge clk);
		req_if.valid <= 1'b1;
		req_if.kind <= o.kind;
		req_if.vertex_id <= o.vid;
		req_if.new_weight <= o.w;
		cur_op <= o;
		do @(posedge clk); while (!(req_if.valid && req_if.ready));
	endtask

	function automatic logic [NEWW_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 7);
			4: return '0;
			5: return W_ABSENT - 1;
			6: return W_ABSENT;
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t pick_op();
		op_t o;
		int r;
		o = '0;
		o.vid = VID_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, NV-1) :
			$urandom_range(0, 11));
		o.w = pick_weight();
		r = $urandom_range(0, 99);
		if (r < 35)
			o.kind = KIND_INSERT;
		else if (r < 45)
			o.kind = KIND_UPDATE;
		else if (r < 60)
			o.kind = KIND_REMOVE;
		else if (r < 70)
			o.kind = KIND_EXISTS;
		else if (r < 95)
			o.kind = KIND_POP;
		else
			o.kind = KIND_W'($urandom_range(KIND_RSVD5, KIND_RSVD7));
		return o;
	endfunction

	initial begin
		op_t o;
		req_if.valid = 1'b0;
		req_if.kind = KIND_INSERT;
		req_if.vertex_id = '0;
		req_if.new_weight = '0;
		rsp_if.ready = 1'b0;
		cur_op = '0;
		mismatches = 0;
		idle_cycles = 0;
		hold_req = 0;
		q_count = 0;
		for (int i = 0; i < NV; i++) begin
			q_slot[i] = '0;
			q_weight[i] = W_ABSENT;
		end
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		add_row(KIND_POP, 0, 0, 1, row_exp(0, 0, ST_EMPTY));
		add_row(KIND_REMOVE, 5, 0, 1, row_exp(0, 0, ST_NOT_FOUND));
		add_row(KIND_EXISTS, 0, 0, 1, row_exp(0, 0, ST_OK));
		add_row(KIND_INSERT, 63, 0, 1, row_exp(0, 0, ST_OK));
		add_row(KIND_EXISTS, 63, 0, 1, row_exp(0, 1, ST_OK));
		add_row(KIND_INSERT, 0, W_ABSENT - 1, 1, row_exp(0, 0, ST_OK));
		// duplicate insert with the absent weight
		add_row(KIND_INSERT, 0, W_ABSENT, 1, row_exp(0, 0, ST_OK));
		add_row(KIND_EXISTS, 0, 0, 1, row_exp(0, 0, ST_OK));
		add_row(KIND_UPDATE, 0, 5, 1, row_exp(0, 0, ST_OK));
		add_row(KIND_UPDATE, 40, 1, 1, row_exp(0, 0, ST_OK));
		add_row(KIND_EXISTS, 40, 0, 1, row_exp(0, 1, ST_OK));
		add_row(KIND_INSERT, 7, 5, 0, '0);
		add_row(KIND_RSVD5, 63, W_ABSENT, 1, row_exp(0, 0, ST_OK));
		add_row(KIND_RSVD6, 63, W_ABSENT, 1, row_exp(0, 0, ST_OK));
		add_row(KIND_RSVD7, 63, W_ABSENT, 1, row_exp(0, 0, ST_OK));
		add_row(KIND_POP, 0, 0, 1, row_exp(63, 0, ST_OK));
		add_row(KIND_POP, 0, 0, 0, '0);
		add_row(KIND_REMOVE, 0, 0, 0, '0);
		add_row(KIND_EXISTS, 7, 0, 0, '0);
		add_row(KIND_POP, 0, 0, 0, '0);
		add_row(KIND_POP, 0, 0, 0, '0);
		add_row(KIND_POP, 0, 0, 0, '0);
		add_row(KIND_REMOVE, 40, 0, 0, '0);

		foreach (directed_ops[i])
			send_op(directed_ops[i]);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == 200)
				hold_req = 1;
			if (n == 300) begin
				// fill past capacity to reach the full-list status
				for (int k = 0; k < NV + 6; k++) begin
					o = '0;
					o.kind = KIND_INSERT;
					o.vid = VID_W'($urandom_range(0, NV-1));
					o.w = pick_weight();
					send_op(o);
				end
			end
			if (n == 500) begin
				@(negedge clk);
				req_if.valid <= 1'b0;
				while (pending_rsp.size() != 0)
					@(posedge clk);
			end
			send_op(pick_op());
		end
		@(negedge clk);
		req_if.valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// response side stalls
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				gap = 400;
				hold_req = 0;
			end else begin
				gap = $urandom_range(0, 16);
				if ($urandom_range(0, 3) == 0)
					gap = 0;
			end
			repeat (gap) begin
				@(negedge clk);
				rsp_if.ready <= 1'b0;
			end
			@(negedge clk);
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
		end
	end

endmodule
